// ===== design/sdrb_pkg.sv =====
// ----------------------------------------------------------------------------
// sdrb_pkg
// Types and constants shared by the SD host register bank modules.
// ----------------------------------------------------------------------------
package sdrb_pkg;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctrl_cmd;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    localparam logic [7:0] OFS_POWER     = 8'h00;
    localparam logic [7:0] OFS_CLOCK     = 8'h04;
    localparam logic [7:0] OFS_ARGUMENT  = 8'h08;
    localparam logic [7:0] OFS_COMMAND   = 8'h0C;
    localparam logic [7:0] OFS_RESP_CMD  = 8'h10;
    localparam logic [7:0] OFS_DATA_TIME = 8'h24;
    localparam logic [7:0] OFS_DATA_LEN  = 8'h28;
    localparam logic [7:0] OFS_DATA_CTRL = 8'h2C;
    localparam logic [7:0] OFS_DATA_CNT  = 8'h30;
    localparam logic [7:0] OFS_STATUS    = 8'h34;
    localparam logic [7:0] OFS_CLEAR     = 8'h38;
    localparam logic [7:0] OFS_MASK      = 8'h3C;

    localparam logic [31:0] BYTE_MASK     = 32'h0000_00FF;
    localparam logic [31:0] HALF_MASK     = 32'h0000_FFFF;
    localparam logic [31:0] WORD_MASK     = 32'hFFFF_FFFF;
    localparam logic [31:0] WAITRESP_MASK = 32'h0000_00C0;
    localparam logic [31:0] CPSM_ENABLE   = 32'h0000_0400;

    localparam logic [7:0] CMD_FLAGS    = 8'hC5;
    localparam logic [7:0] FLAG_TIMEOUT = 8'h04;
    localparam logic [7:0] FLAG_SENT    = 8'h80;

    function automatic logic [31:0] lane_mask(input logic [1:0] size);
        logic [31:0] m;
        case (size)
            SIZE_BYTE: m = BYTE_MASK;
            SIZE_HALF: m = HALF_MASK;
            default:   m = WORD_MASK;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] merge(input logic [31:0] old_v,
                                          input logic [31:0] data,
                                          input logic [31:0] m);
        return (old_v & ~m) | (data & m);
    endfunction

endpackage

// ===== design/sdrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdrb_ctrl
// Access sequencer: captures a request, runs it, strobes the result.
// ----------------------------------------------------------------------------
module sdrb_ctrl
    import sdrb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    output t_ctrl_cmd o_cmd,
    output logic      o_done
);

    t_state r_state, n_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.execute;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        busy          = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                busy          = 1'b1;
                o_cmd.execute = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

// ===== design/sdrb_datapath.sv =====
// ----------------------------------------------------------------------------
// sdrb_datapath
// Register file, lane merge, command side effects and read mux.
// ----------------------------------------------------------------------------
module sdrb_datapath
    import sdrb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl_cmd   i_cmd,
    input  logic        i_req_type,
    input  logic [7:0]  i_reg_offset,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_write_data,
    output logic [31:0] o_read_data
);

    // captured request word
    logic        r_req_type;
    logic [7:0]  r_offset;
    logic [1:0]  r_size;
    logic [31:0] r_wdata;

    logic [1:0]  r_power,   n_power;
    logic [31:0] r_clock,   n_clock;
    logic [31:0] r_arg,     n_arg;
    logic [31:0] r_cmd,     n_cmd;
    logic [5:0]  r_cmd_idx, n_cmd_idx;
    logic [31:0] r_dtimer,  n_dtimer;
    logic [31:0] r_dlen,    n_dlen;
    logic [31:0] r_dctrl,   n_dctrl;
    logic [31:0] r_dcount,  n_dcount;
    logic [7:0]  r_status,  n_status;
    logic [31:0] r_irqmask, n_irqmask;
    logic [31:0] r_rdata,   n_rdata;

    logic [31:0] m;
    logic [31:0] merged_cmd;
    logic [31:0] rd_v;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_offset   <= i_reg_offset;
            r_size     <= i_access_size;
            r_wdata    <= i_write_data;
        end
        if (i_cmd.execute) begin
            r_rdata <= n_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power   <= '0;
            r_clock   <= '0;
            r_arg     <= '0;
            r_cmd     <= '0;
            r_cmd_idx <= '0;
            r_dtimer  <= '0;
            r_dlen    <= '0;
            r_dctrl   <= '0;
            r_dcount  <= '0;
            r_status  <= '0;
            r_irqmask <= '0;
        end else if (i_cmd.execute) begin
            r_power   <= n_power;
            r_clock   <= n_clock;
            r_arg     <= n_arg;
            r_cmd     <= n_cmd;
            r_cmd_idx <= n_cmd_idx;
            r_dtimer  <= n_dtimer;
            r_dlen    <= n_dlen;
            r_dctrl   <= n_dctrl;
            r_dcount  <= n_dcount;
            r_status  <= n_status;
            r_irqmask <= n_irqmask;
        end
    end

    assign m          = lane_mask(r_size);
    assign merged_cmd = merge(r_cmd, r_wdata, m);

    always_comb begin
        n_power   = r_power;
        n_clock   = r_clock;
        n_arg     = r_arg;
        n_cmd     = r_cmd;
        n_cmd_idx = r_cmd_idx;
        n_dtimer  = r_dtimer;
        n_dlen    = r_dlen;
        n_dctrl   = r_dctrl;
        n_dcount  = r_dcount;
        n_status  = r_status;
        n_irqmask = r_irqmask;
        if (r_req_type == REQ_WRITE) begin
            case (r_offset)
                OFS_POWER:     n_power = r_wdata[1:0] & m[1:0];
                OFS_CLOCK:     n_clock = merge(r_clock, r_wdata, m);
                OFS_ARGUMENT:  n_arg   = merge(r_arg, r_wdata, m);
                OFS_COMMAND: begin
                    n_cmd     = merged_cmd;
                    n_cmd_idx = merged_cmd[5:0];
                    n_status  = r_status & ~CMD_FLAGS;
                    // command machine completes at once
                    if ((merged_cmd & CPSM_ENABLE) != '0) begin
                        if ((merged_cmd & WAITRESP_MASK) == '0) begin
                            n_status = n_status | FLAG_SENT;
                        end else begin
                            n_status = n_status | FLAG_TIMEOUT;
                        end
                    end
                end
                OFS_DATA_TIME: n_dtimer = merge(r_dtimer, r_wdata, m);
                OFS_DATA_LEN: begin
                    n_dlen   = merge(r_dlen, r_wdata, m);
                    n_dcount = n_dlen;
                end
                OFS_DATA_CTRL: n_dctrl   = merge(r_dctrl, r_wdata, m);
                OFS_CLEAR:     n_status  = r_status & ~(r_wdata[7:0] & m[7:0]);
                OFS_MASK:      n_irqmask = merge(r_irqmask, r_wdata, m);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_offset)
            OFS_POWER:     rd_v = {30'd0, r_power};
            OFS_CLOCK:     rd_v = r_clock;
            OFS_ARGUMENT:  rd_v = r_arg;
            OFS_COMMAND:   rd_v = r_cmd;
            OFS_RESP_CMD:  rd_v = {26'd0, r_cmd_idx};
            OFS_DATA_TIME: rd_v = r_dtimer;
            OFS_DATA_LEN:  rd_v = r_dlen;
            OFS_DATA_CTRL: rd_v = r_dctrl;
            OFS_DATA_CNT:  rd_v = r_dcount;
            OFS_STATUS:    rd_v = {24'd0, r_status};
            OFS_MASK:      rd_v = r_irqmask;
            default:       rd_v = '0;
        endcase
        n_rdata = (r_req_type == REQ_READ) ? (rd_v & m) : '0;
    end

    assign o_read_data = r_rdata;

endmodule

// ===== design/sd_host_register_bank_top.sv =====
// ----------------------------------------------------------------------------
// sd_host_register_bank_top
// Register bank of an SD host controller, one bus access at a time.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (i_req_type, i_reg_offset, i_access_size, i_write_data)
//   is taken at the rising edge where start is high and busy is low.
//   The next cycle busy is high while the access runs against the
//   register file; the edge ending it updates the registers and the
//   read data register.
//   o_done is high for exactly one cycle, once the execute state has
//   ended, with o_read_data valid in that cycle (zero for writes).
//   An access is captured in the idle state of the sequencer and run in
//   its execute state. A new request can be taken in the cycle
//   where o_done is high.
//   The receiver cannot stall: every result appears once, for one cycle.
//   Reset (i_rst_n low, synchronous) returns the sequencer to idle,
//   drops o_done and clears every register of the bank to zero.
// ----------------------------------------------------------------------------
module sd_host_register_bank_top
    import sdrb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [7:0]  i_reg_offset,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_write_data,
    output logic        o_done,
    output logic [31:0] o_read_data
);

    t_ctrl_cmd cmd;

    sdrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .o_done  (o_done)
    );

    sdrb_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req_type    (i_req_type),
        .i_reg_offset  (i_reg_offset),
        .i_access_size (i_access_size),
        .i_write_data  (i_write_data),
        .o_read_data   (o_read_data)
    );

endmodule

// ===== design/sdrb_checker.sv =====
// ----------------------------------------------------------------------------
// sdrb_checker
// Port-level timing checks for the SD host register bank.
// ----------------------------------------------------------------------------
module sdrb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_req_type,
    input logic        o_done,
    input logic [31:0] o_read_data
);

    // every accepted word gives a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result strobe missing after accept");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // a strobe only follows a running access, with busy high
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("strobe without a running access");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_req_type, 2)) |-> (o_read_data == 32'd0))
        else $error("write returned nonzero data");

endmodule

bind sd_host_register_bank_top sdrb_checker u_sdrb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_req_type  (i_req_type),
    .o_done      (o_done),
    .o_read_data (o_read_data)
);

// ===== tb/tb_sd_host_register_bank_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sd_host_register_bank_top
// Self-checking bench for the SD host register bank: a directed table walks
// reset values, lane merging, the command flags and the dead offsets, then
// random bus accesses run in phases with and without sender gaps. Every read
// data word is compared in order against a shadow copy of the bank or a table value.
// ----------------------------------------------------------------------------
module tb_sd_host_register_bank_top;
    import sdrb_pkg::*;

    localparam logic [1:0] SIZE_WORD     = 2'd2;
    localparam logic [1:0] SIZE_ODD      = 2'd3;   // decodes as a word
    localparam logic [7:0] OFS_RESP0     = 8'h14;
    localparam logic [7:0] OFS_FIFO_CNT  = 8'h48;
    localparam logic [7:0] OFS_FIFO_BASE = 8'h80;
    localparam logic [5:0] CMD_IDX_MASK  = 6'h3F;
    localparam int         DIR_N         = 25;
    localparam int         PHASE_ITEMS   = 400;
    localparam int         CYCLE_LIMIT   = 200_000;
    localparam int         DRAIN_LIMIT   = 64;

    typedef struct packed {
        logic        req;
        logic [7:0]  ofs;
        logic [1:0]  size;
        logic [31:0] data;
        logic        fixed;
        logic [31:0] exp_rd;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_req_type;
    logic [7:0]  i_reg_offset;
    logic [1:0]  i_access_size;
    logic [31:0] i_write_data;
    logic        o_done;
    logic [31:0] o_read_data;

    // expectation that rides along with the word on the bus
    logic        cur_fixed;
    logic [31:0] cur_exp;

    // shadow of the bank
    logic [1:0]  pwr_q;
    logic [31:0] clkdiv_q;
    logic [31:0] arg_q;
    logic [31:0] cmd_q;
    logic [5:0]  idx_q;
    logic [31:0] dtimer_q;
    logic [31:0] dlen_q;
    logic [31:0] dctrl_q;
    logic [31:0] dcnt_q;
    logic [7:0]  status_q;
    logic [31:0] imask_q;

    logic [31:0] read_data_q [$];
    t_row        dir_tbl [DIR_N];
    int          phase_gap [4] = '{0, 87, 0, 38};
    int          acc_cnt = 0;
    int          err_cnt = 0;
    int          cycle_cnt = 0;

    sd_host_register_bank_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_reg_offset  (i_reg_offset),
        .i_access_size (i_access_size),
        .i_write_data  (i_write_data),
        .o_done        (o_done),
        .o_read_data   (o_read_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        err_cnt++;
        if (err_cnt <= 40) begin
            $display("cycle %0d: %s", cycle_cnt, what);
        end
    endtask

    // applies one access to the shadow bank and returns its read data
    task automatic bank_access(input logic req, input logic [7:0] ofs,
                               input logic [1:0] size, input logic [31:0] data,
                               output logic [31:0] rd);
        logic [31:0] m;
        logic [31:0] dm;
        logic [31:0] v;
        m  = (size == SIZE_BYTE) ? BYTE_MASK : (size == SIZE_HALF) ? HALF_MASK : WORD_MASK;
        dm = data & m;
        v  = '0;
        rd = '0;
        if (req == REQ_WRITE) begin
            case (ofs)
                OFS_POWER:     pwr_q    = (pwr_q & ~m[1:0]) | dm[1:0];
                OFS_CLOCK:     clkdiv_q = (clkdiv_q & ~m) | dm;
                OFS_ARGUMENT:  arg_q    = (arg_q & ~m) | dm;
                OFS_COMMAND: begin
                    cmd_q    = (cmd_q & ~m) | dm;
                    idx_q    = cmd_q[5:0] & CMD_IDX_MASK;
                    status_q = status_q & ~CMD_FLAGS;
                    if ((cmd_q & CPSM_ENABLE) != '0) begin
                        // no response awaited means the command is simply sent
                        if ((cmd_q & WAITRESP_MASK) == '0) status_q = status_q | FLAG_SENT;
                        else status_q = status_q | FLAG_TIMEOUT;
                    end
                end
                OFS_DATA_TIME: dtimer_q = (dtimer_q & ~m) | dm;
                OFS_DATA_LEN: begin
                    dlen_q = (dlen_q & ~m) | dm;
                    dcnt_q = dlen_q;
                end
                OFS_DATA_CTRL: dctrl_q  = (dctrl_q & ~m) | dm;
                OFS_CLEAR:     status_q = status_q & ~dm[7:0];
                OFS_MASK:      imask_q  = (imask_q & ~m) | dm;
                default: ;
            endcase
        end else begin
            case (ofs)
                OFS_POWER:     v = {30'd0, pwr_q};
                OFS_CLOCK:     v = clkdiv_q;
                OFS_ARGUMENT:  v = arg_q;
                OFS_COMMAND:   v = cmd_q;
                OFS_RESP_CMD:  v = {26'd0, idx_q};
                OFS_DATA_TIME: v = dtimer_q;
                OFS_DATA_LEN:  v = dlen_q;
                OFS_DATA_CTRL: v = dctrl_q;
                OFS_DATA_CNT:  v = dcnt_q;
                OFS_STATUS:    v = {24'd0, status_q};
                OFS_MASK:      v = imask_q;
                default:       v = '0;
            endcase
            rd = v & m;
        end
    endtask

    // mostly the decoded map, now and then any byte of the window
    function automatic logic [7:0] pick_offset();
        logic [7:0] o;
        case ($urandom_range(0, 19))
            0:  o = OFS_POWER;
            1:  o = OFS_CLOCK;
            2:  o = OFS_ARGUMENT;
            3:  o = OFS_COMMAND;
            4:  o = OFS_RESP_CMD;
            5:  o = OFS_RESP0 + 8'($urandom_range(0, 3) * 4);
            6:  o = OFS_DATA_TIME;
            7:  o = OFS_DATA_LEN;
            8:  o = OFS_DATA_CTRL;
            9:  o = OFS_DATA_CNT;
            10: o = OFS_STATUS;
            11: o = OFS_CLEAR;
            12: o = OFS_MASK;
            13: o = OFS_FIFO_CNT;
            14: o = OFS_FIFO_BASE + 8'($urandom_range(0, 31) * 4);
            default: o = 8'($urandom_range(0, 255));
        endcase
        return o;
    endfunction

    task automatic send_word(input logic req, input logic [7:0] ofs, input logic [1:0] size,
                             input logic [31:0] data, input logic fixed,
                             input logic [31:0] exp_rd, input int gap_pct);
        int seen;
        while ($urandom_range(0, 99) < gap_pct) begin
            start        <= 1'b0;
            i_write_data <= $urandom();
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_req_type    <= req;
        i_reg_offset  <= ofs;
        i_access_size <= size;
        i_write_data  <= data;
        cur_fixed     <= fixed;
        cur_exp       <= exp_rd;
        seen = acc_cnt;
        do @(negedge i_clk); while (acc_cnt == seen);
    endtask

    always @(posedge i_clk) begin : monitor
        logic [31:0] exp_rd;
        cycle_cnt++;
        if (i_rst_n) begin
            if (o_done) begin
                if (read_data_q.size() == 0) begin
                    report_mismatch($sformatf("done with no word pending, data %h",
                                              o_read_data));
                end else begin
                    exp_rd = read_data_q.pop_front();
                    if (o_read_data !== exp_rd) begin
                        report_mismatch($sformatf("read_data %h, expected %h",
                                                  o_read_data, exp_rd));
                    end
                end
            end
            if (start && !busy) begin
                bank_access(i_req_type, i_reg_offset, i_access_size, i_write_data, exp_rd);
                if (cur_fixed) exp_rd = cur_exp;
                read_data_q.push_back(exp_rd);
                acc_cnt++;
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        t_row        r;
        logic        req;
        logic [31:0] data;
        int          w;
        start         = 1'b0;
        i_req_type    = REQ_READ;
        i_reg_offset  = '0;
        i_access_size = SIZE_BYTE;
        i_write_data  = '0;
        cur_fixed     = 1'b0;
        cur_exp       = '0;
        i_rst_n       = 1'b0;
        {pwr_q, clkdiv_q, arg_q, cmd_q, idx_q, dtimer_q} = '0;
        {dlen_q, dctrl_q, dcnt_q, status_q, imask_q} = '0;

        dir_tbl = '{
            '{REQ_READ,  OFS_POWER,     SIZE_WORD, 32'h0000_0000, 1'b1, 32'h0},
            '{REQ_READ,  OFS_STATUS,    SIZE_WORD, 32'h0000_0000, 1'b1, 32'h0},
            '{REQ_WRITE, OFS_POWER,     SIZE_BYTE, 32'hFFFF_FFFF, 1'b1, 32'h0},
            '{REQ_READ,  OFS_POWER,     SIZE_WORD, 32'h0000_0000, 1'b1, 32'h3},
            '{REQ_WRITE, OFS_CLOCK,     SIZE_WORD, 32'hFFFF_FFFF, 1'b1, 32'h0},
            '{REQ_WRITE, OFS_CLOCK,     SIZE_BYTE, 32'h0000_0000, 1'b1, 32'h0},
            '{REQ_READ,  OFS_CLOCK,     SIZE_WORD, 32'h0000_0000, 1'b0, 32'h0},
            '{REQ_READ,  OFS_CLOCK,     SIZE_HALF, 32'h0000_0000, 1'b0, 32'h0},
            '{REQ_WRITE, OFS_ARGUMENT,  SIZE_HALF, 32'h8000_ABCD, 1'b1, 32'h0},
            '{REQ_READ,  OFS_ARGUMENT,  SIZE_WORD, 32'h0000_0000, 1'b0, 32'h0},
            '{REQ_WRITE, OFS_DATA_LEN,  SIZE_HALF, 32'h1234_5678, 1'b1, 32'h0},
            '{REQ_READ,  OFS_DATA_CNT,  SIZE_WORD, 32'h0000_0000, 1'b0, 32'h0},
            // enabled, no response awaited: command sent
            '{REQ_WRITE, OFS_COMMAND,   SIZE_WORD, 32'h0000_043F, 1'b1, 32'h0},
            '{REQ_READ,  OFS_STATUS,    SIZE_BYTE, 32'h0000_0000, 1'b0, 32'h0},
            '{REQ_READ,  OFS_RESP_CMD,  SIZE_WORD, 32'h0000_0000, 1'b0, 32'h0},
            // byte write keeps the enable bit, now a response is awaited
            '{REQ_WRITE, OFS_COMMAND,   SIZE_BYTE, 32'hFFFF_FBC1, 1'b1, 32'h0},
            '{REQ_READ,  OFS_STATUS,    SIZE_WORD, 32'h0000_0000, 1'b0, 32'h0},
            '{REQ_WRITE, OFS_CLEAR,     SIZE_BYTE, 32'hFFFF_FFFF, 1'b1, 32'h0},
            '{REQ_READ,  OFS_STATUS,    SIZE_WORD, 32'h0000_0000, 1'b1, 32'h0},
            '{REQ_WRITE, OFS_STATUS,    SIZE_WORD, 32'hFFFF_FFFF, 1'b1, 32'h0},
            '{REQ_READ,  OFS_RESP0,     SIZE_WORD, 32'h0000_0000, 1'b1, 32'h0},
            '{REQ_READ,  OFS_FIFO_CNT,  SIZE_WORD, 32'h0000_0000, 1'b1, 32'h0},
            '{REQ_WRITE, OFS_MASK,      SIZE_ODD,  32'hFFFF_FFFF, 1'b1, 32'h0},
            '{REQ_READ,  OFS_MASK,      SIZE_ODD,  32'h0000_0000, 1'b0, 32'h0},
            '{REQ_READ,  OFS_MASK + 8'd1, SIZE_WORD, 32'h0000_0000, 1'b1, 32'h0}
        };

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_N; i++) begin
            r = dir_tbl[i];
            send_word(r.req, r.ofs, r.size, r.data, r.fixed, r.exp_rd, 0);
        end

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                req  = ($urandom_range(0, 1) == 1) ? REQ_WRITE : REQ_READ;
                data = $urandom();
                send_word(req, pick_offset(), 2'($urandom_range(0, 3)), data, 1'b0, '0,
                          phase_gap[ph]);
            end
        end
        start <= 1'b0;

        w = 0;
        while (read_data_q.size() != 0 && w < DRAIN_LIMIT) begin
            @(posedge i_clk);
            w++;
        end
        repeat (4) @(posedge i_clk);
        if (read_data_q.size() != 0) begin
            report_mismatch($sformatf("%0d read words never returned", read_data_q.size()));
        end

        if (err_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
